// File: design/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// shared constants and types of the rgb half downscaler
// ----------------------------------------------------------------------------
package rhd_pkg;

    localparam int RHD_MAX_WIDTH  = 2048;   // default line store sizing
    localparam int RHD_MAX_HEIGHT = 2048;
    localparam int CFG_W          = 12;     // width and height registers
    localparam int ROW_W          = 11;     // row counter
    localparam int CH_W           = 8;      // one colour channel
    localparam int PIX_W          = 3 * CH_W;
    localparam int SUM_W          = 12;     // one channel partial sum
    localparam int PSUM_W         = 3 * SUM_W;
    localparam int IDX_W          = 2;      // configuration register index

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd2;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd2;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             weighted;
    } t_cfg;

    // one output request on its way to the output register
    typedef struct packed {
        logic              use_mem;   // upper sums come from the line store
        logic              weighted;  // shift by four, else by two
        logic              last;      // final pixel of the frame
        logic [PSUM_W-1:0] up;        // upper sums when not from the line store
        logic [PSUM_W-1:0] low;       // lower row sums
    } t_s1;

endpackage

// File: design/rgb_half_downscale_core.sv
// ----------------------------------------------------------------------------
// rgb_half_downscale_core
// halves an rgb raster image in both directions, 2x2 box or 9-3-3-1 weights
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request per clock while s_axis_tready is
// high, for an image of the configured width and height; every 2x2 block gives
// one output pixel, in box mode the floor of the mean of the four samples and
// in weighted mode floor((9*tl + 3*tr + 3*bl + br) / 16) per channel. An odd
// last column or row is replicated. The upper row of each block is folded into
// per channel partial sums kept in a line store of (MAX_WIDTH+1)/2 words of 36
// bits; the lower row reads them back, so an output appears only when the lower
// right pixel of its block is taken. Throughput is one pixel per clock with no
// bubbles while the output is accepted: each pixel makes at most one line store
// access, a write on upper rows or a read on lower rows, and the line store
// takes one of each per cycle. Each output is registered first in the request
// register, alongside the line store read, then in the output register. The
// line store needs no clearing after reset. Width and height are clamped to
// 1..MAX_WIDTH and 1..2048; registers should be written only while no frame is
// in flight. m_axis_tlast marks the final output pixel of a frame.
module rgb_half_downscale_core #(
    parameter int MAX_WIDTH = rhd_pkg::RHD_MAX_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rhd_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [rhd_pkg::CFG_W-1:0] i_cfg_data,
    // pixel input: red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [rhd_pkg::PIX_W-1:0] s_axis_tdata,
    // pixel output: red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [rhd_pkg::PIX_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);

    import rhd_pkg::*;

    localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_cfg              r_cfg;
    logic              s1_valid;
    t_s1               s1;
    logic              take;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PSUM_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [PSUM_W-1:0] ram_rdata;

    // configuration registers, writes always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= WIDTH_RST;
            r_cfg.height   <= HEIGHT_RST;
            r_cfg.weighted <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_cfg.width    <= i_cfg_data;
                REG_HEIGHT: r_cfg.height   <= i_cfg_data;
                REG_MODE:   r_cfg.weighted <= i_cfg_data[0];
                default:    ;   // unused index, write dropped
            endcase
        end
    end

    // position tracking, partial sums and line store requests
    rhd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixel     (s_axis_tdata),
        .i_take      (take),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    // line store of upper row partial sums, three 12 bit channels per word
    rhd_ram #(
        .WIDTH (PSUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // combine, scale and hold the output pixel
    rhd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_rdata    (ram_rdata),
        .o_take     (take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

// File: design/rhd_ram.sv
// ----------------------------------------------------------------------------
// rhd_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rhd_ram #(
    parameter  int WIDTH = 36,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rhd_front.sv
// ----------------------------------------------------------------------------
// rhd_front
// raster position, pair forming, partial sums and line store access
// ----------------------------------------------------------------------------
module rhd_front #(
    parameter  int MAX_WIDTH   = rhd_pkg::RHD_MAX_WIDTH,
    localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2,
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rhd_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rhd_pkg::PIX_W-1:0]  i_pixel,
    input  logic                       i_take,
    output logic                       o_s1_valid,
    output rhd_pkg::t_s1               o_s1,
    output logic                       o_ram_we,
    output logic [AW-1:0]              o_ram_waddr,
    output logic [rhd_pkg::PSUM_W-1:0] o_ram_wdata,
    output logic                       o_ram_re,
    output logic [AW-1:0]              o_ram_raddr
);

    import rhd_pkg::*;

    localparam int PW = $clog2(MAX_WIDTH);
    localparam int XW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;

    // per channel wa*a + wb*b, upper row weights 9,3 or 1,1
    function automatic logic [PSUM_W-1:0] f_upper(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic wmode);
        logic [PSUM_W-1:0] res;
        logic [SUM_W-1:0]  ca;
        logic [SUM_W-1:0]  cb;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            ca = SUM_W'(a[k*CH_W +: CH_W]);
            cb = SUM_W'(b[k*CH_W +: CH_W]);
            res[k*SUM_W +: SUM_W] = wmode ? ((ca << 3) + ca + (cb << 1) + cb) : (ca + cb);
        end
        return res;
    endfunction

    // lower row weights 3,1 or 1,1
    function automatic logic [PSUM_W-1:0] f_lower(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic wmode);
        logic [PSUM_W-1:0] res;
        logic [SUM_W-1:0]  ca;
        logic [SUM_W-1:0]  cb;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            ca = SUM_W'(a[k*CH_W +: CH_W]);
            cb = SUM_W'(b[k*CH_W +: CH_W]);
            res[k*SUM_W +: SUM_W] = wmode ? ((ca << 1) + ca + cb) : (ca + cb);
        end
        return res;
    endfunction

    logic [PW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_held;
    logic             r_s1_valid;
    t_s1              r_s1;

    logic [XW-1:0]    w_ext;
    logic [XW-1:0]    w_eff;
    logic [XW-1:0]    col_inc;
    logic [CFG_W-1:0] h_eff;
    logic [CFG_W-1:0] row_inc;
    logic             last_col;
    logic             last_row;
    logic             accept;
    logic             pair_done;
    logic             emit;
    logic [PIX_W-1:0] left_pix;
    logic [PSUM_W-1:0] up_sum;
    t_s1              n_s1;

    // sizes held to their legal range
    always_comb begin
        w_ext = XW'(i_cfg.width);
        if (w_ext == '0) begin
            w_eff = XW'(1);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (i_cfg.height == '0) begin
            h_eff = CFG_W'(1);
        end else if (i_cfg.height > CFG_W'(RHD_MAX_HEIGHT)) begin
            h_eff = CFG_W'(RHD_MAX_HEIGHT);
        end else begin
            h_eff = i_cfg.height;
        end
    end

    assign col_inc   = XW'(r_col) + XW'(1);
    assign row_inc   = CFG_W'(r_row) + CFG_W'(1);
    assign last_col  = (col_inc >= w_eff);
    assign last_row  = (row_inc >= h_eff);

    assign o_ready   = !r_s1_valid || i_take;
    assign accept    = i_valid && o_ready;
    // odd column closes a pair; a lone last column pairs with itself
    assign pair_done = r_col[0] || last_col;
    assign emit      = pair_done && (r_row[0] || last_row);
    assign left_pix  = r_col[0] ? r_held : i_pixel;
    assign up_sum    = f_upper(left_pix, i_pixel, i_cfg.weighted);

    always_comb begin
        n_s1.use_mem  = r_row[0];
        n_s1.weighted = i_cfg.weighted;
        n_s1.last     = last_row && last_col;
        n_s1.up       = up_sum;
        n_s1.low      = f_lower(left_pix, i_pixel, i_cfg.weighted);
    end

    assign o_ram_we    = accept && pair_done && !r_row[0] && !last_row;
    assign o_ram_waddr = AW'(r_col >> 1);
    assign o_ram_wdata = up_sum;
    assign o_ram_re    = accept && pair_done && r_row[0];
    assign o_ram_raddr = AW'(r_col >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (!pair_done) begin
                    r_held <= i_pixel;
                end
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : ROW_W'(row_inc);
                end else begin
                    r_col <= PW'(col_inc);
                end
            end
            if (accept && emit) begin
                r_s1_valid <= 1'b1;
            end else if (i_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    a_ram_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_we && o_ram_re))
        else $error("line store written and read in one cycle");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit) |=> r_s1_valid)
        else $error("emitted request lost before output stage");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit && n_s1.last) |=> (r_col == '0 && r_row == '0))
        else $error("position not wrapped after last pixel of frame");

endmodule

// File: design/rhd_back.sv
// ----------------------------------------------------------------------------
// rhd_back
// adds upper and lower sums, scales, saturates and holds the output
// ----------------------------------------------------------------------------
module rhd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_valid,
    input  rhd_pkg::t_s1               i_s1,
    input  logic [rhd_pkg::PSUM_W-1:0] i_rdata,
    output logic                       o_take,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rhd_pkg::PIX_W-1:0]  o_data,
    output logic                       o_last
);

    import rhd_pkg::*;

    logic              r_valid;
    logic [PIX_W-1:0]  r_data;
    logic              r_last;
    logic [PSUM_W-1:0] up;
    logic [PIX_W-1:0]  n_data;
    logic [SUM_W:0]    total [3];
    logic [SUM_W:0]    scaled [3];

    assign up     = i_s1.use_mem ? i_rdata : i_s1.up;
    assign o_take = !r_valid || i_ready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            total[k]  = (SUM_W+1)'(up[k*SUM_W +: SUM_W])
                      + (SUM_W+1)'(i_s1.low[k*SUM_W +: SUM_W]);
            scaled[k] = i_s1.weighted ? (total[k] >> 4) : (total[k] >> 2);
            // only reachable when the mode changed between the two rows
            n_data[k*CH_W +: CH_W] = (scaled[k] > (SUM_W+1)'(255)) ? 8'hFF
                                                                  : scaled[k][CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_s1_valid) begin
            r_data <= n_data;
            r_last <= i_s1.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule
